### design/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the sorted triple set
// Holds the triple layout, the operation and status codes, the controller
// command and datapath status groups, and the triple ordering function.
// ----------------------------------------------------------------------------
package sts_pkg;

   // One stored word: key, value and source, all signed.
   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] val;
      logic signed [31:0] src;
   } triple_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_DELETE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       commit;
      logic       respond;
      status_type code;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_delete;
      logic found;
      logic full;
   } dp_status_type;

   // Lexicographic signed order: key first, then val, then src.
   function automatic logic triple_less(input triple_type a, input triple_type b);
      logic result;
      begin
         if (a.key != b.key) begin
            result = (a.key < b.key);
         end else if (a.val != b.val) begin
            result = (a.val < b.val);
         end else begin
            result = (a.src < b.src);
         end
         return result;
      end
   endfunction

endpackage

### design/sorted_triple_set_core.sv
// ----------------------------------------------------------------------------
// sorted_triple_set_core: ordered set of (key, val, src) triples
// Sequence: the broadcast compare runs in the accept cycle, the cell row shifts
// in the apply cycle, and rsp_valid and the result word are registered there.
// A new word is not taken while busy, that is while the previous word is being
// applied; the next word can be accepted while the result strobe is high.
// Reset (synchronous) empties the set and clears the controller and strobe;
// the stored words themselves are not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_triple_set_core #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_val,
   input  logic signed [31:0] req_src,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_count
);
   import sts_pkg::*;

   // The controller owns sequencing and the status decision; the datapath
   // owns the cell row, the fill count and the response word.
   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // A request is taken when start is high and busy is low. In that same
   // cycle every cell compares its stored word with the request, and the
   // less-than and equal flags are registered together with the request.
   sts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // In the apply cycle the flags are reduced to a found bit, the status
   // is settled, and if the operation succeeds the whole row shifts at the
   // boundary cell in one step. The response word is registered at the end of the
   // apply cycle with the count after the operation.
   sts_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_func   (req_func),
      .req_key    (req_key),
      .req_val    (req_val),
      .req_src    (req_src),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

endmodule

### design/sts_ctrl.sv
// ----------------------------------------------------------------------------
// sts_ctrl: operation controller of the sorted triple set
// Two-state machine that captures a request, then resolves the status and
// tells the datapath whether to commit the shift.
// ----------------------------------------------------------------------------
module sts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sts_pkg::dp_status_type dp_status,
   output sts_pkg::ctrl_cmd_type cmd,
   output logic                  rsp_valid
);
   import sts_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_APPLY = 2'b10
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   status_type code;

   // Status precedence: a duplicate insert wins over a full table.
   always_comb begin
      priority if (dp_status.is_delete) begin
         code = dp_status.found ? ST_DONE : ST_NOT_FOUND;
      end else if (dp_status.found) begin
         code = ST_DUPLICATE;
      end else if (dp_status.full) begin
         code = ST_FULL;
      end else begin
         code = ST_DONE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd.capture  = 1'b0;
      cmd.commit   = 1'b0;
      cmd.respond  = 1'b0;
      cmd.code     = code;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.commit   = (code == ST_DONE);
            cmd.respond  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff == S_APPLY);
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/sts_datapath.sv
// ----------------------------------------------------------------------------
// sts_datapath: row of compare-and-shift cells of the sorted triple set
// Every cell compares its word with the request in the accept cycle; the
// registered flags then steer a shift up or down the row.
// ----------------------------------------------------------------------------
module sts_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_func,
   input  logic signed [31:0]     req_key,
   input  logic signed [31:0]     req_val,
   input  logic signed [31:0]     req_src,
   input  sts_pkg::ctrl_cmd_type  cmd,
   output sts_pkg::dp_status_type dp_status,
   output logic [1:0]             rsp_status,
   output logic [6:0]             rsp_count
);
   import sts_pkg::*;

   localparam int USED_W = $clog2(CAPACITY + 1);

   triple_type          cell_ff [CAPACITY];
   triple_type          cell_in [CAPACITY];
   triple_type          req_triple;
   triple_type          t_ff;
   logic                func_ff;
   logic [CAPACITY-1:0] lt_ff;
   logic [CAPACITY-1:0] lt_in;
   logic [CAPACITY-1:0] eq_ff;
   logic [CAPACITY-1:0] eq_in;
   logic [USED_W-1:0]   used_ff;
   logic [USED_W-1:0]   used_in;
   logic [1:0]          rsp_status_ff;
   logic [USED_W+6:0]   count_ext;

   assign req_triple.key = req_key;
   assign req_triple.val = req_val;
   assign req_triple.src = req_src;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic       occupied;
         triple_type below;
         triple_type above;
         logic       lt_below;

         assign occupied = (used_ff > USED_W'(i));
         assign lt_in[i] = occupied && triple_less(cell_ff[i], req_triple);
         assign eq_in[i] = occupied && (cell_ff[i] == req_triple);

         if (i == 0) begin : g_first
            assign below    = t_ff;
            assign lt_below = 1'b1;
         end else begin : g_inner
            assign below    = cell_ff[i-1];
            assign lt_below = lt_ff[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign above = cell_ff[i];
         end else begin : g_upper
            assign above = cell_ff[i+1];
         end

         // Smaller words stay put; the rest move up on insert, down on delete.
         assign cell_in[i] = lt_ff[i] ? cell_ff[i] :
                             (func_ff == FUNC_DELETE) ? above :
                             lt_below ? t_ff : below;
      end
   endgenerate

   assign dp_status.is_delete = (func_ff == FUNC_DELETE);
   assign dp_status.found     = |eq_ff;
   assign dp_status.full      = (used_ff == USED_W'(CAPACITY));

   assign used_in = (func_ff == FUNC_DELETE) ? used_ff - USED_W'(1)
                                             : used_ff + USED_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         t_ff    <= req_triple;
         func_ff <= req_func;
         lt_ff   <= lt_in;
         eq_ff   <= eq_in;
      end
      if (cmd.commit) begin
         for (int j = 0; j < CAPACITY; j++) begin
            cell_ff[j] <= cell_in[j];
         end
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.commit) begin
         used_ff <= used_in;
      end
   end

   assign count_ext  = {7'b0, used_ff};
   assign rsp_count  = count_ext[6:0];
   assign rsp_status = rsp_status_ff;

endmodule

### design/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker: port-level checks of the sorted triple set
// Watches the top-level ports for sequencing and count consistency.
// ----------------------------------------------------------------------------
module sts_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [6:0] rsp_count
);
   import sts_pkg::*;

   // An accepted word keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // Busy is followed in the next cycle by idle and the result strobe.
   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy && rsp_valid)
      else $error("busy not followed by a result");

   // A result is only shown while the block is ready for the next word.
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // A refused operation leaves the count as it was when the word came in.
   a_refused_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |-> rsp_count == $past(rsp_count, 2))
      else $error("refused operation changed the count");

endmodule

bind sorted_triple_set_core sts_checker u_sts_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status),
   .rsp_count  (rsp_count)
);
